### sv/hmsd_pkg.sv
// shared types and constants for the histogram mean and deviation engine
`timescale 1ns / 1ps

package hmsd_pkg;

  // item field widths
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned OUT_W  = 18;

  // running total widths
  localparam int unsigned N_W    = 34;
  localparam int unsigned S1_W   = 44;
  localparam int unsigned S2_W   = 54;
  localparam int unsigned PROD_W = 44;
  localparam int unsigned MUL_W  = 88;

  // saturation value of every result
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_DIVM,
    S_MULA,
    S_MULB,
    S_SQRT,
    S_DIVS,
    S_OUT
  } state_e;

endpackage

### sv/histogram_mean_sd_engine_core.sv
// Histogram mean and deviation engine: fragment-length histogram summary.
//
// Input channel (in_valid_i / in_stall_o) takes one bin count per word, bin
// index 0 first; last_bin_i closes the run, and bin MAX_BINS-1 always does.
// Output channel (out_valid_o / out_stall_i) gives exactly one word per bin:
// the truncated mean of the bins so far and, on the closing bin, the overall
// mean and standard deviation in unsigned Q10.8 (FRAC_BITS fraction bits),
// rounded toward zero and saturated, or the empty-histogram flag.
// A bin that needs the mean takes three accumulate steps through one small
// multiplier, then the bit-serial divider (FRAC_BITS + 44 steps); a bin zero
// that does not close, bins with no count yet and an empty close skip the divider.
// The closing bin takes the same, plus a shift-add 88-bit multiply-subtract
// (78 steps), a two-bits-a-step square root (FRAC_BITS + 44 steps) and a
// second pass through the divider.
// One bin is in work at a time; in_stall_o is high until its word is in the
// output register. A word waiting under out_stall_i does not block the next
// bin; a finished word waits only if the register is still full.
// Reset clears the totals and the bin index; they also clear after each run.
`timescale 1ns / 1ps

module histogram_mean_sd_engine_core import hmsd_pkg::*; #(
  parameter int unsigned MAX_BINS  = 1024,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CNT_W-1:0] bin_count_i,
  input  logic             last_bin_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OUT_W-1:0] trunc_mean_o,
  output logic             trunc_valid_o,
  output logic [OUT_W-1:0] mean_length_o,
  output logic [OUT_W-1:0] sd_length_o,
  output logic             stats_valid_o,
  output logic             empty_histogram_o,
  output logic             run_done_o
);

  localparam int unsigned RT_W   = S1_W + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(RT_W);

  state_e state_q, state_d;

  // running totals and bin position
  logic [IDX_W-1:0] idx_q;
  logic [N_W-1:0]   cnt_n_q;
  logic [S1_W-1:0]  s1_q;
  logic [S2_W-1:0]  s2_q;

  // per-item working registers
  logic [CNT_W-1:0]  cnt_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_q;
  logic [MUL_W-1:0]  acc_q;
  logic [MUL_W-1:0]  mcand_q;
  logic [S1_W-1:0]   mplier_q;
  logic [RT_W-1:0]   root_q;
  logic [RT_W+1:0]   rem_q;
  logic [STEP_W-1:0] step_q;
  logic [OUT_W-1:0]  mean_res_q;
  logic [OUT_W-1:0]  sd_res_q;

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] trunc_mean_q;
  logic             trunc_valid_q;
  logic [OUT_W-1:0] mean_length_q;
  logic [OUT_W-1:0] sd_length_q;
  logic             stats_valid_q;
  logic             empty_q;
  logic             run_done_q;

  // control strobes
  logic in_acc;
  logic out_load;
  logic div_start;
  logic div_done;
  logic need_div;
  logic nz;
  logic tval;
  logic mul_end_a;
  logic mul_end_b;
  logic sqrt_end;

  logic [PROD_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [MUL_W-1:0]  addend;
  logic [MUL_W-1:0]  acc_step;
  logic [RT_W+3:0]   rem_sh;
  logic [RT_W+3:0]   trial;
  logic [RT_W+4:0]   sdiff;
  logic              sq_ge;
  logic [RT_W-1:0]   root_d;
  logic [RT_W+1:0]   rem_d;
  logic [RT_W-1:0]   div_dvd;
  logic [OUT_W-1:0]  div_quot;

  // shared small multiplier: count times index, then that times index
  always_comb begin
    mul_a = (state_q == S_MUL1) ? PROD_W'(cnt_q) : PROD_W'(prod_q[N_W-1:0]);
    mul_p = PROD_W'(mul_a[N_W-1:0]) * PROD_W'(idx_q);
  end

  // shift-add unit for N*S2 - S1*S1
  always_comb begin
    addend   = mplier_q[0] ? mcand_q : '0;
    acc_step = (state_q == S_MULB) ? (acc_q - addend) : (acc_q + addend);
  end

  // square root, two radicand bits a step
  always_comb begin
    rem_sh = {rem_q, acc_q[MUL_W-1:MUL_W-2]};
    trial  = (RT_W+4)'({root_q, 2'b01});
    sdiff  = {1'b0, rem_sh} - {1'b0, trial};
    sq_ge  = ~sdiff[RT_W+4];
    root_d = {root_q[RT_W-2:0], sq_ge};
    rem_d  = sq_ge ? sdiff[RT_W+1:0] : rem_sh[RT_W+1:0];
  end

  // status terms
  always_comb begin
    nz        = (cnt_n_q != '0);
    tval      = (idx_q != '0) && nz;
    need_div  = nz && ((idx_q != '0) || last_q);
    mul_end_a = (step_q == STEP_W'(N_W - 1));
    mul_end_b = (step_q == STEP_W'(S1_W - 1));
    sqrt_end  = (step_q == STEP_W'(RT_W - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_ACC;
      S_ACC:  state_d = need_div ? S_DIVM : S_OUT;
      S_DIVM: if (div_done) state_d = last_q ? S_MULA : S_OUT;
      S_MULA: if (mul_end_a) state_d = S_MULB;
      S_MULB: if (mul_end_b) state_d = S_SQRT;
      S_SQRT: if (sqrt_end) state_d = S_DIVS;
      S_DIVS: if (div_done) state_d = S_OUT;
      S_OUT:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_acc     = (state_q == S_IDLE) && in_valid_i;
    out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
    div_start  = ((state_q == S_ACC) && need_div) || ((state_q == S_SQRT) && sqrt_end);
    div_dvd    = (state_q == S_ACC) ? (RT_W'(s1_q) << FRAC_BITS) : root_d;
  end

  // shared divider for the mean and the deviation
  hmsd_div #(
    .DW (RT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cnt_n_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // state, totals and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_n_q     <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_n_q <= cnt_n_q + N_W'(bin_count_i);
      end
      if (state_q == S_MUL2) begin
        s1_q <= s1_q + prod_q;
      end
      if (state_q == S_ACC) begin
        s2_q <= s2_q + S2_W'(prod_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          idx_q   <= '0;
          cnt_n_q <= '0;
          s1_q    <= '0;
          s2_q    <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_q  <= bin_count_i;
          last_q <= last_bin_i || (idx_q == IDX_W'(MAX_BINS - 1));
        end
      end
      S_MUL1, S_MUL2: begin
        prod_q <= mul_p;
      end
      S_DIVM: begin
        if (div_done) begin
          mean_res_q <= div_quot;
          acc_q      <= '0;
          mcand_q    <= MUL_W'(s2_q);
          mplier_q   <= S1_W'(cnt_n_q);
          step_q     <= '0;
        end
      end
      S_MULA: begin
        acc_q <= acc_step;
        if (mul_end_a) begin
          mcand_q  <= MUL_W'(s1_q);
          mplier_q <= s1_q;
          step_q   <= '0;
        end else begin
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          step_q   <= step_q + 1'b1;
        end
      end
      S_MULB: begin
        acc_q    <= acc_step;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (mul_end_b) begin
          root_q <= '0;
          rem_q  <= '0;
          step_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      S_SQRT: begin
        acc_q  <= acc_q << 2;
        root_q <= root_d;
        rem_q  <= rem_d;
        step_q <= step_q + 1'b1;
      end
      S_DIVS: begin
        if (div_done) begin
          sd_res_q <= div_quot;
        end
      end
      S_OUT: begin
        if (out_load) begin
          trunc_mean_q  <= tval ? mean_res_q : '0;
          trunc_valid_q <= tval;
          mean_length_q <= (last_q && nz) ? mean_res_q : '0;
          sd_length_q   <= (last_q && nz) ? sd_res_q : '0;
          stats_valid_q <= last_q && nz;
          empty_q       <= last_q && !nz;
          run_done_q    <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign trunc_mean_o      = trunc_mean_q;
  assign trunc_valid_o     = trunc_valid_q;
  assign mean_length_o     = mean_length_q;
  assign sd_length_o       = sd_length_q;
  assign stats_valid_o     = stats_valid_q;
  assign empty_histogram_o = empty_q;
  assign run_done_o        = run_done_q;

`ifndef SYNTHESIS
  // an accepted word always starts the accumulate sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MUL1))
    else $error("accepted word did not start accumulation");

  // a closing word carries either statistics or the empty flag, never both
  a_close_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_done_o) |-> (stats_valid_o != empty_histogram_o))
    else $error("closing word flags inconsistent");

  // statistics only appear on a closing word
  a_stats_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (stats_valid_o || empty_histogram_o)) |-> run_done_o)
    else $error("statistics outside a closing word");

  // index, count and S1 total are cleared once the closing word is loaded
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> ((idx_q == '0) && (cnt_n_q == '0) && (s1_q == '0)))
    else $error("totals not cleared after closing bin");

  // the divider only reports back while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_DIVM) || (state_q == S_DIVS)))
    else $error("divider finished outside a wait state");
`endif

endmodule

### sv/hmsd_div.sv
// restoring divider, one quotient bit per cycle, saturating quotient
`timescale 1ns / 1ps

module hmsd_div import hmsd_pkg::*; #(
  parameter int unsigned DW = 52
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [N_W-1:0]   divisor_i,
  output logic             done_o,
  output logic [OUT_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [N_W-1:0] dsr_q;
  logic [N_W-1:0] rem_q;
  logic [OUT_W-1:0] quo_q;
  logic          ovf_q;

  logic [N_W:0]   sh;
  logic [N_W+1:0] diff;
  logic           ge;

  // trial subtract of the shifted remainder
  always_comb begin
    sh   = {rem_q, dvd_q[DW-1]};
    diff = {1'b0, sh} - {2'b00, dsr_q};
    ge   = ~diff[N_W+1];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[N_W-1:0] : sh[N_W-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[OUT_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[OUT_W-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? OUT_MAX : quo_q;

endmodule

### verif/hmsd_checker.sv
// result checker for the histogram mean and deviation engine
`timescale 1ns / 1ps

module hmsd_checker import hmsd_pkg::*; #(
  parameter int unsigned MAX_BINS  = 1024,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [CNT_W-1:0] bin_count_i,
  input  logic             last_bin_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [OUT_W-1:0] trunc_mean_i,
  input  logic             trunc_valid_i,
  input  logic [OUT_W-1:0] mean_length_i,
  input  logic [OUT_W-1:0] sd_length_i,
  input  logic             stats_valid_i,
  input  logic             empty_histogram_i,
  input  logic             run_done_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  // one result word, fields in port order
  typedef struct packed {
    logic [OUT_W-1:0] trunc_mean;
    logic             trunc_valid;
    logic [OUT_W-1:0] mean_length;
    logic [OUT_W-1:0] sd_length;
    logic             stats_valid;
    logic             empty_histogram;
    logic             run_done;
  } bin_summary_t;

  // running totals of the current histogram
  logic [IDX_W-1:0] bin_idx;
  logic [N_W-1:0]   tot_count;
  logic [S1_W-1:0]  tot_mass;
  logic [S2_W-1:0]  tot_sq_mass;

  bin_summary_t summary_q[$];
  bin_summary_t got_word;
  bin_summary_t want_word;

  function automatic logic [OUT_W-1:0] clamp_out(input logic [127:0] v);
    return (v > 128'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  // bit-by-bit floor square root of a 128-bit value
  function automatic logic [63:0] int_sqrt(input logic [127:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (({64'd0, cand} * {64'd0, cand}) <= x) root = cand;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] mean_fixed(input logic [N_W-1:0] n,
                                                  input logic [S1_W-1:0] s1);
    return clamp_out((128'(s1) << FRAC_BITS) / 128'(n));
  endfunction

  // sd = floor(sqrt((s2*n - s1^2) << 2F) / n)
  function automatic logic [OUT_W-1:0] sd_fixed(input logic [N_W-1:0] n,
                                                input logic [S1_W-1:0] s1,
                                                input logic [S2_W-1:0] s2);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] spread;
    lhs = 128'(s2) * 128'(n);
    rhs = 128'(s1) * 128'(s1);
    if (rhs > lhs) return '0;
    spread = (lhs - rhs) << (2 * FRAC_BITS);
    return clamp_out(128'(int_sqrt(spread)) / 128'(n));
  endfunction

  // fold one bin into the totals and work out its result word
  function automatic bin_summary_t summarize_bin(input logic [CNT_W-1:0] cnt,
                                                 input logic last_in);
    logic [IDX_W-1:0] idx;
    logic             closing;
    bin_summary_t     r;
    idx     = bin_idx;
    closing = last_in || (int'(idx) >= int'(MAX_BINS) - 1);
    tot_count   = tot_count + N_W'(cnt);
    tot_mass    = tot_mass + S1_W'(cnt) * S1_W'(idx);
    tot_sq_mass = tot_sq_mass + S2_W'(cnt) * S2_W'(idx) * S2_W'(idx);
    r = '0;
    if (idx != '0 && tot_count != '0) begin
      r.trunc_mean  = mean_fixed(tot_count, tot_mass);
      r.trunc_valid = 1'b1;
    end
    if (closing) begin
      if (tot_count != '0) begin
        r.mean_length = mean_fixed(tot_count, tot_mass);
        r.sd_length   = sd_fixed(tot_count, tot_mass, tot_sq_mass);
        r.stats_valid = 1'b1;
      end else begin
        r.empty_histogram = 1'b1;
      end
      r.run_done  = 1'b1;
      bin_idx     = '0;
      tot_count   = '0;
      tot_mass    = '0;
      tot_sq_mass = '0;
    end else begin
      bin_idx = idx + 1'b1;
    end
    return r;
  endfunction

  // predict on accepted bins, compare accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_idx      = '0;
      tot_count    = '0;
      tot_mass     = '0;
      tot_sq_mass  = '0;
      summary_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        summary_q.insert(summary_q.size(), summarize_bin(bin_count_i, last_bin_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got_word = {trunc_mean_i, trunc_valid_i, mean_length_i, sd_length_i,
                    stats_valid_i, empty_histogram_i, run_done_i};
        if (summary_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) begin
            $display("[%0t] result word with nothing expected: tmean=%0d tv=%0b mean=%0d",
                     $realtime, got_word.trunc_mean, got_word.trunc_valid,
                     got_word.mean_length);
          end
        end else begin
          want_word = summary_q.pop_front();
          checked_o = checked_o + 1;
          if (got_word !== want_word) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("[%0t] word %0d expected tmean=%0d tv=%0b mean=%0d sd=%0d sv=%0b e=%0b d=%0b",
                       $realtime, checked_o, want_word.trunc_mean, want_word.trunc_valid,
                       want_word.mean_length, want_word.sd_length, want_word.stats_valid,
                       want_word.empty_histogram, want_word.run_done);
              $display("[%0t] word %0d actual   tmean=%0d tv=%0b mean=%0d sd=%0d sv=%0b e=%0b d=%0b",
                       $realtime, checked_o, got_word.trunc_mean, got_word.trunc_valid,
                       got_word.mean_length, got_word.sd_length, got_word.stats_valid,
                       got_word.empty_histogram, got_word.run_done);
            end
          end
        end
      end
      pending_o = summary_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// testbench top: stimulus, handshake pacing and verdict for the histogram engine
`timescale 1ns / 1ps

module tb_top import hmsd_pkg::*;;

  localparam int unsigned MAX_BINS     = 1024;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int          RANDOM_ITEMS = 526;
  localparam int          DRAIN_CYCLES = 3 * FRAC_BITS + 300;
  localparam int          CYCLE_LIMIT  = 1000000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CNT_W-1:0] bin_count_i;
  logic             last_bin_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [OUT_W-1:0] trunc_mean_o;
  logic             trunc_valid_o;
  logic [OUT_W-1:0] mean_length_o;
  logic [OUT_W-1:0] sd_length_o;
  logic             stats_valid_o;
  logic             empty_histogram_o;
  logic             run_done_o;

  int fail_count;
  int pending_words;
  int checked_words;
  int cycle_count;
  int bins_sent;
  int runs_sent;
  int empty_runs;
  int random_bins;
  bit calm;

  histogram_mean_sd_engine_core #(
    .MAX_BINS  (MAX_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .bin_count_i       (bin_count_i),
    .last_bin_i        (last_bin_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .trunc_mean_o      (trunc_mean_o),
    .trunc_valid_o     (trunc_valid_o),
    .mean_length_o     (mean_length_o),
    .sd_length_o       (sd_length_o),
    .stats_valid_o     (stats_valid_o),
    .empty_histogram_o (empty_histogram_o),
    .run_done_o        (run_done_o)
  );

  hmsd_checker #(
    .MAX_BINS  (MAX_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .bin_count_i       (bin_count_i),
    .last_bin_i        (last_bin_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .trunc_mean_i      (trunc_mean_o),
    .trunc_valid_i     (trunc_valid_o),
    .mean_length_i     (mean_length_o),
    .sd_length_i       (sd_length_o),
    .stats_valid_i     (stats_valid_o),
    .empty_histogram_i (empty_histogram_o),
    .run_done_i        (run_done_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending_words),
    .checked_o         (checked_words)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending_words);
    $display("end of test: mismatches");
    $finish;
  end

  // count mix: zeros, small values, full range and values near the top
  function automatic logic [CNT_W-1:0] draw_count();
    logic [CNT_W-1:0] c;
    case ($urandom_range(0, 3))
      0: begin
        c = '0;
      end
      1: begin
        c = CNT_W'($urandom_range(0, 15));
      end
      2: begin
        c = CNT_W'($urandom);
      end
      default: begin
        c = {CNT_W{1'b1}} - CNT_W'($urandom_range(0, 15));
      end
    endcase
    return c;
  endfunction

  // present one bin word after a random gap and wait until it is taken
  task automatic send_bin(input logic [CNT_W-1:0] cnt, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    bin_count_i = cnt;
    last_bin_i  = last;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    bins_sent = bins_sent + 1;
  endtask

  // one histogram: kind 0 is all zero, kind 1 full-range counts, else mixed
  task automatic send_run(input int len, input int kind);
    logic [CNT_W-1:0] cnt;
    bit               any_mass;
    any_mass = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (kind == 0) cnt = '0;
      else if (kind == 1) cnt = CNT_W'($urandom);
      else cnt = draw_count();
      if (cnt != '0) any_mass = 1'b1;
      send_bin(cnt, i == len - 1);
      random_bins = random_bins + 1;
    end
    runs_sent = runs_sent + 1;
    if (!any_mass) empty_runs = empty_runs + 1;
  endtask

  // directed runs given as a flat list of counts with run boundaries
  task automatic send_directed();
    logic [CNT_W-1:0] counts [24];
    bit               closes [24];
    counts = '{24'h000000, 24'hFFFFFF,
               24'h000000, 24'h000000, 24'h000000,
               24'h000000, 24'h000000, 24'h000005, 24'h000000, 24'h000009,
               24'hFFFFFF, 24'hFFFFFF,
               24'h000001, 24'h000000, 24'h000000, 24'hFFFFFF,
               24'h000000, 24'hFFFFFF, 24'h000001,
               24'h000003, 24'h000007, 24'hAAAAAA, 24'h555555, 24'h800000};
    closes = '{1, 1, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1,
               0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1};
    for (int i = 0; i < 24; i++) begin
      send_bin(counts[i], closes[i]);
      if (closes[i]) runs_sent = runs_sent + 1;
    end
    // single empty bin, three empty bins
    empty_runs = empty_runs + 2;
  endtask

  // receiver: per word, hold stall for a random number of cycles once it shows
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      out_stall_i = (hold != 0);
      do @(posedge clk_i); while (!out_valid_o);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int  len;
    int  kind;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    bin_count_i = '0;
    last_bin_i  = 1'b0;
    bins_sent   = 0;
    runs_sent   = 0;
    empty_runs  = 0;
    random_bins = 0;
    calm        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();

    while (random_bins < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      kind = $urandom_range(0, 9);
      send_run(len, kind);
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i = 1'b0;

    // drain
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d bins in %0d histograms, %0d of them empty",
             bins_sent, runs_sent, empty_runs);
    $display("summary: %0d result words compared, %0d failures", checked_words, fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
